// ===== rtl/mmr_pkg.sv =====
// ----------------------------------------------------------------------------
// mmr_pkg: shared types and constants of the min/max range rescaler
// Sizes of the sample store, arithmetic widths, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mmr_pkg;

  // Frame capacity (2..64)
  localparam int unsigned MaxSamples = 64;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned CntW       = $clog2(MaxSamples + 1);

  localparam int unsigned DataW  = 16;           // sample / target width
  localparam int unsigned WideW  = DataW + 1;    // differences of two samples
  localparam int unsigned ProdW  = 2 * DataW + 1; // signed product of diff and span
  localparam int unsigned MagW   = 2 * DataW;    // product magnitude
  localparam int unsigned QuotW  = DataW;        // quotient magnitude
  localparam int unsigned StepW  = $clog2(QuotW);
  localparam int unsigned SumW   = DataW + 2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgOutLow  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgOutHigh = 1'd1;

  localparam logic signed [DataW-1:0] OutLowRst  = 16'sd0;
  localparam logic signed [DataW-1:0] OutHighRst = 16'sd32767;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // sample beat accepted
    logic rd;         // read next stored sample
    logic mul;        // form (x - min) * span
    logic div_start;  // launch the divider
    logic fin;        // finish result into output register
    logic clear;      // end of frame, reset frame state
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic res_last;   // result in output register is the frame's last
    logic div_done;   // divider has a quotient
  } stat_t;

endpackage

// ===== rtl/min_max_range_rescaler.sv =====
// ----------------------------------------------------------------------------
// min_max_range_rescaler: frame-based min/max range normalizer
// Stores a frame of signed 16-bit samples and replays them linearly
// rescaled so the frame minimum maps to out_low and the maximum to out_high.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis_*): one sample per beat, tlast marks the frame's
//    last sample. Up to 64 samples are stored; further beats are dropped,
//    excluded from min/max, and flag the frame as overflowed.
//  - Output stream (m_axis_*): one beat per stored sample, in arrival order,
//    scaled = (x - min) * (out_high - out_low) / (max - min) + out_low,
//    quotient truncated toward zero, clamped to 16 bits. A flat frame
//    (max == min) yields out_low with the flat flag set.
//  - Config port: cfg_we_i writes cfg_wdata_i into out_low (index 0) or
//    out_high (index 1). Write only while no frame is in flight.
//  - Loading accepts one sample per cycle. Each result, when the sink is
//    ready, goes through RAM read, multiply, radix-2 divider start and run,
//    finish, and the output beat; results are produced one at a time.
//  - s_axis_tready is low from the frame's last beat until its last result
//    is taken; loading of the next frame starts the cycle after that.
//  - A stalled sink holds the result register and freezes the sequencer.
//  - Reset: out_low = 0, out_high = 32767, frame state cleared, both
//    streams idle. The sample store itself is not cleared.
// ----------------------------------------------------------------------------
module min_max_range_rescaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [15:0] sample
  input  logic                              s_axis_tlast,  // frame_end
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [15:0] scaled
  output logic                              m_axis_tlast,  // is_last
  output logic [1:0]                        m_axis_tuser,  // [0] flat_frame, [1] overflowed
  // configuration
  input  logic                              cfg_we_i,
  input  logic [mmr_pkg::CfgIdxW-1:0]       cfg_addr_i,
  input  logic [mmr_pkg::DataW-1:0]         cfg_wdata_i
);

  mmr_pkg::cmd_t                    cmd;
  mmr_pkg::stat_t                   stat;
  logic signed [mmr_pkg::DataW-1:0] scaled;
  logic                             flat, ovf;

  // Sequencer: handshakes and command strobes
  mmr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tlast_i (s_axis_tlast),
    .s_tready_o(s_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Store, statistics, multiply/divide and result register
  mmr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   ($signed(s_axis_tdata)),
    .scaled_o   (scaled),
    .is_last_o  (m_axis_tlast),
    .flat_o     (flat),
    .ovf_o      (ovf)
  );

  assign m_axis_tdata = scaled;
  assign m_axis_tuser = {ovf, flat};

endmodule

// ===== rtl/mmr_ram.sv =====
// ----------------------------------------------------------------------------
// mmr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mmr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mmr_div.sv =====
// ----------------------------------------------------------------------------
// mmr_div: radix-2 restoring divider
// Unsigned divide of a 32-bit magnitude by a 16-bit divisor, one quotient
// bit per cycle. The caller guarantees the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module mmr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mmr_pkg::MagW-1:0]    dividend_i,
  input  logic [mmr_pkg::DataW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [mmr_pkg::QuotW-1:0]   quot_o
);

  logic [mmr_pkg::DataW-1:0]  rem_q, rem_d;
  logic [mmr_pkg::QuotW-1:0]  shf_q, shf_d;
  logic [mmr_pkg::StepW-1:0]  step_q, step_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [mmr_pkg::DataW:0]    trial;
  logic                       ge;

  // shf holds the low dividend bits on the way out and quotient bits on the way in
  assign trial = {rem_q, shf_q[mmr_pkg::QuotW-1]};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    rem_d  = rem_q;
    shf_d  = shf_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[mmr_pkg::MagW-1 -: mmr_pkg::DataW];
      shf_d  = dividend_i[mmr_pkg::QuotW-1:0];
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? mmr_pkg::DataW'(trial - {1'b0, divisor_i})
                  : trial[mmr_pkg::DataW-1:0];
      shf_d  = {shf_q[mmr_pkg::QuotW-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == mmr_pkg::StepW'(mmr_pkg::QuotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
  end

  assign done_o = done_q;
  assign quot_o = shf_q;

endmodule

// ===== rtl/mmr_datapath.sv =====
// ----------------------------------------------------------------------------
// mmr_datapath: store, min/max tracking and rescale arithmetic
// Holds the target registers, the sample RAM, frame statistics, the
// multiplier stage, the divider and the output payload register.
// ----------------------------------------------------------------------------
module mmr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmr_pkg::cmd_t                       cmd_i,
  output mmr_pkg::stat_t                      stat_o,
  input  logic                                cfg_we_i,
  input  logic [mmr_pkg::CfgIdxW-1:0]         cfg_addr_i,
  input  logic [mmr_pkg::DataW-1:0]           cfg_wdata_i,
  input  logic signed [mmr_pkg::DataW-1:0]    sample_i,
  output logic signed [mmr_pkg::DataW-1:0]    scaled_o,
  output logic                                is_last_o,
  output logic                                flat_o,
  output logic                                ovf_o
);

  logic signed [mmr_pkg::DataW-1:0] out_low_q, out_high_q;
  logic [mmr_pkg::CntW-1:0]         count_q, rd_idx_q;
  logic signed [mmr_pkg::DataW-1:0] min_q, max_q;
  logic                             drop_q;
  logic                             has_room;
  logic [mmr_pkg::DataW-1:0]        rdata;

  logic signed [mmr_pkg::WideW-1:0] range_w, diff, span;
  logic [mmr_pkg::DataW-1:0]        range_u;
  logic                             flat;
  logic signed [mmr_pkg::ProdW-1:0] prod_q;
  logic                             neg_q;
  logic [mmr_pkg::MagW-1:0]         mag;
  logic                             div_done;
  logic [mmr_pkg::QuotW-1:0]        quot;
  logic signed [mmr_pkg::WideW-1:0] quot_s;
  logic signed [mmr_pkg::SumW-1:0]  sum;
  logic signed [mmr_pkg::DataW-1:0] sat;

  logic                             last_pend_q;
  logic signed [mmr_pkg::DataW-1:0] scaled_q;
  logic                             is_last_q, flat_q, ovf_q;

  // Target registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_low_q  <= mmr_pkg::OutLowRst;
      out_high_q <= mmr_pkg::OutHighRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        mmr_pkg::CfgOutLow:  out_low_q  <= cfg_wdata_i;
        mmr_pkg::CfgOutHigh: out_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign has_room = (count_q < mmr_pkg::CntW'(mmr_pkg::MaxSamples));

  // Frame statistics and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      min_q       <= '0;
      max_q       <= '0;
      drop_q      <= 1'b0;
      last_pend_q <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      min_q    <= '0;
      max_q    <= '0;
      drop_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (has_room) begin
          count_q <= count_q + 1'b1;
          if (count_q == '0) begin
            min_q <= sample_i;
            max_q <= sample_i;
          end else begin
            if (sample_i < min_q) min_q <= sample_i;
            if (sample_i > max_q) max_q <= sample_i;
          end
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.rd) begin
        rd_idx_q    <= rd_idx_q + 1'b1;
        last_pend_q <= ((rd_idx_q + 1'b1) == count_q);
      end
    end
  end

  mmr_ram #(
    .Width(mmr_pkg::DataW),
    .Depth(mmr_pkg::MaxSamples)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load & has_room),
    .waddr_i(count_q[mmr_pkg::AddrW-1:0]),
    .wdata_i(sample_i),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_idx_q[mmr_pkg::AddrW-1:0]),
    .rdata_o(rdata)
  );

  // range = max - min is never negative; span may be
  assign range_w = {max_q[mmr_pkg::DataW-1], max_q} - {min_q[mmr_pkg::DataW-1], min_q};
  assign range_u = range_w[mmr_pkg::DataW-1:0];
  assign flat    = (range_u == '0);
  assign diff    = {rdata[mmr_pkg::DataW-1], rdata} - {min_q[mmr_pkg::DataW-1], min_q};
  assign span    = {out_high_q[mmr_pkg::DataW-1], out_high_q}
                 - {out_low_q[mmr_pkg::DataW-1], out_low_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= mmr_pkg::ProdW'(diff) * mmr_pkg::ProdW'(span);
    end
    if (cmd_i.div_start) begin
      neg_q <= prod_q[mmr_pkg::ProdW-1];
    end
  end

  // |product| <= 65535 * 65535 fits the magnitude width
  assign mag = prod_q[mmr_pkg::ProdW-1] ? mmr_pkg::MagW'(-prod_q)
                                       : prod_q[mmr_pkg::MagW-1:0];

  mmr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(mag),
    .divisor_i (range_u),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Signed quotient truncates toward zero; then offset and clamp
  assign quot_s = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign sum    = mmr_pkg::SumW'(quot_s) + mmr_pkg::SumW'(out_low_q);

  always_comb begin
    if (sum > mmr_pkg::SumW'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -mmr_pkg::SumW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[mmr_pkg::DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      scaled_q  <= flat ? out_low_q : sat;
      is_last_q <= last_pend_q;
      flat_q    <= flat;
      ovf_q     <= drop_q;
    end
  end

  assign stat_o.res_last = is_last_q;
  assign stat_o.div_done = div_done;

  assign scaled_o  = scaled_q;
  assign is_last_o = is_last_q;
  assign flat_o    = flat_q;
  assign ovf_o     = ovf_q;

endmodule

// ===== rtl/mmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmr_ctrl: frame sequencer
// Loads samples until the last beat of a frame, then walks the store one
// result at a time through multiply, divide and output handshake.
// ----------------------------------------------------------------------------
module mmr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  logic            s_tlast_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  mmr_pkg::stat_t  stat_i,
  output mmr_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StLoad,
    StRead,
    StMult,
    StDivGo,
    StDivWait,
    StFin,
    StSend
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   s_beat, m_beat;

  assign s_beat = s_tvalid_i & (state_q == StLoad);
  assign m_beat = m_tvalid_q & m_tready_i;

  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q;
    case (state_q)
      StLoad:    if (s_beat && s_tlast_i) state_d = StRead;
      StRead:    state_d = StMult;
      StMult:    state_d = StDivGo;
      StDivGo:   state_d = StDivWait;
      StDivWait: if (stat_i.div_done) state_d = StFin;
      StFin: begin
        state_d    = StSend;
        m_tvalid_d = 1'b1;
      end
      StSend: begin
        if (m_beat) begin
          m_tvalid_d = 1'b0;
          state_d    = stat_i.res_last ? StLoad : StRead;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = s_beat;
    cmd_o.rd        = (state_q == StRead);
    cmd_o.mul       = (state_q == StMult);
    cmd_o.div_start = (state_q == StDivGo);
    cmd_o.fin       = (state_q == StFin);
    cmd_o.clear     = (state_q == StSend) & m_beat & stat_i.res_last;
  end

  assign s_tready_o = (state_q == StLoad);
  assign m_tvalid_o = m_tvalid_q;

endmodule

// ===== sim/tb_min_max_range_rescaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_max_range_rescaler: self-checking bench for the min/max rescaler
// Streams frames of signed samples into the block and predicts each rescaled
// output beat from its own frame store, min/max tracker and output range.
// Runs a directed opener, then random frames under several range settings.
// Both stream sides pause and stall at random.
// ----------------------------------------------------------------------------
module tb_min_max_range_rescaler;
  import mmr_pkg::*;

  // Longest stretch without any beat or register write before giving up.
  // It is well above what one result needs plus the longest sink stall, and
  // the pauses between settings are far shorter than this limit.
  localparam int unsigned IdleLimit  = 2000;
  // Settle time after the last result, well above one result's latency
  localparam int unsigned TailCycles = 60;
  localparam int unsigned NumRanges  = 8;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    frame_end;
  } sample_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] scaled;
    logic                    is_last;
    logic                    flat_frame;
    logic                    overflowed;
  } scaled_beat_t;

  // How the samples of a random frame are picked
  typedef enum int unsigned {
    FrmWide,    // any 16-bit value
    FrmNarrow,  // within 8 codes of a random base
    FrmEdges,   // mostly the extremes, zero and -1
    FrmFlat     // one value repeated
  } frame_kind_e;

  // --------------------------------------------------------------------------
  // Clock, reset, block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // [15:0] sample
  logic                s_axis_tlast  = 1'b0; // frame_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // [15:0] scaled
  logic                m_axis_tlast;        // is_last
  logic [1:0]          m_axis_tuser;        // [0] flat_frame, [1] overflowed
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i  = CfgOutLow;
  logic [DataW-1:0]    cfg_wdata_i = '0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  min_max_range_rescaler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the frame and the output range
  // --------------------------------------------------------------------------
  logic signed [DataW-1:0] frame_store [MaxSamples];
  int unsigned             frame_cnt     = 0;
  logic signed [DataW-1:0] frame_lo      = '0;
  logic signed [DataW-1:0] frame_hi      = '0;
  logic                    frame_dropped = 1'b0;
  logic signed [DataW-1:0] out_low_q     = OutLowRst;
  logic signed [DataW-1:0] out_high_q    = OutHighRst;

  sample_beat_t sample_q[$];      // beats still to be sent
  scaled_beat_t scaled_due_q[$];  // rescaled beats still to come out

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned frames_closed   = 0;
  int unsigned flat_frames     = 0;
  int unsigned dropped_frames  = 0;

  bit          in_acc, out_acc;   // beat taken at the last rising edge
  int unsigned send_gap   = 0;
  int unsigned sink_stall = 0;
  bit          send_calm  = 1'b0;
  bit          sink_calm  = 1'b0;
  int unsigned idle_cycles = 0;

  // Take one sample into the frame. On frame_end, replay the stored samples
  // rescaled into the current output range and clear the frame.
  function automatic void absorb_sample(logic signed [DataW-1:0] smp, logic fend);
    longint       span, range, q;
    scaled_beat_t r;
    if (frame_cnt < MaxSamples) begin
      frame_store[frame_cnt] = smp;
      if (frame_cnt == 0) begin
        frame_lo = smp;
        frame_hi = smp;
      end else begin
        if (smp < frame_lo) frame_lo = smp;
        if (smp > frame_hi) frame_hi = smp;
      end
      frame_cnt++;
    end else begin
      // full store: sample is lost, but a frame_end on it still closes
      frame_dropped = 1'b1;
    end
    if (!fend) return;

    span  = longint'(out_high_q) - longint'(out_low_q);
    range = longint'(frame_hi) - longint'(frame_lo);
    for (int i = 0; i < frame_cnt; i++) begin
      // product at full width first, then divide (truncates toward zero)
      if (range == 0) q = longint'(out_low_q);
      else q = (longint'(frame_store[i]) - longint'(frame_lo)) * span / range
               + longint'(out_low_q);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.scaled     = q[DataW-1:0];
      r.is_last    = (i + 1 == frame_cnt);
      r.flat_frame = (range == 0);
      r.overflowed = frame_dropped;
      scaled_due_q.push_back(r);
    end
    frames_closed++;
    if (range == 0) flat_frames++;
    if (frame_dropped) dropped_frames++;
    frame_cnt     = 0;
    frame_lo      = '0;
    frame_hi      = '0;
    frame_dropped = 1'b0;
  endfunction

  // Mostly short pauses, a few long ones
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: samples both streams and the register port at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    scaled_beat_t want;
    in_acc  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_acc = rst_ni && m_axis_tvalid && m_axis_tready;

    if (rst_ni && cfg_we_i) begin
      case (cfg_addr_i)
        CfgOutLow:  out_low_q  = cfg_wdata_i;
        CfgOutHigh: out_high_q = cfg_wdata_i;
        default: ;
      endcase
    end

    if (in_acc) absorb_sample(s_axis_tdata, s_axis_tlast);

    if (out_acc) begin
      if (scaled_due_q.size() == 0) begin
        $display("%0t: result beat with nothing pending, scaled %0d", $time,
                 $signed(m_axis_tdata));
        mismatches++;
      end else begin
        want = scaled_due_q.pop_front();
        check_field("scaled", want.scaled, $signed(m_axis_tdata));
        check_field("is_last", want.is_last, m_axis_tlast);
        check_field("flat_frame", want.flat_frame, m_axis_tuser[0]);
        check_field("overflowed", want.overflowed, m_axis_tuser[1]);
        results_checked++;
      end
    end
  end

  // Watchdog: any beat or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready)
        || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles, %0d results pending", $time,
               idle_cycles, scaled_due_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sample driver: pops the pending queue at the falling edge. tvalid stays
  // high across back-to-back beats; gaps go between beats.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    sample_beat_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_acc)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        nxt = sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.sample;
        s_axis_tlast  <= nxt.frame_end;
        // occasionally flip into / out of a stretch with no gaps at all
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : pick_pause();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, independent of tvalid
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        if (!sink_calm && $urandom_range(0, 3) == 0) sink_stall = pick_pause();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_sample(logic signed [DataW-1:0] smp, logic fend);
    sample_beat_t b;
    b.sample    = smp;
    b.frame_end = fend;
    sample_q.push_back(b);
  endtask

  task automatic add_frame(int unsigned len, frame_kind_e kind);
    logic signed [DataW-1:0] base, v;
    base = DataW'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        FrmWide:   v = DataW'($urandom);
        FrmNarrow: v = base + DataW'($urandom_range(0, 7));
        FrmEdges: begin
          case ($urandom_range(0, 4))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = '0;
            3:       v = -16'sd1;
            default: v = DataW'($urandom);
          endcase
        end
        default:   v = base;
      endcase
      push_sample(v, i == len - 1);
    end
  endtask

  // Random frames, mostly short, until at least n samples are queued
  task automatic add_random_frames(int unsigned n);
    int unsigned queued, len;
    queued = 0;
    while (queued < n) begin
      len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      add_frame(len, frame_kind_e'($urandom_range(0, 3)));
      queued += len;
    end
  endtask

  // Waits until everything sent has come back out, then lets the
  // block settle before anything else happens.
  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid || scaled_due_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [DataW-1:0] lows  [NumRanges];
    logic signed [DataW-1:0] highs [NumRanges];

    // full range, inverted full range, zero span, both targets pinned at
    // each extreme, an ordinary window and two random ones
    lows[0]  = 16'sh8000; highs[0] = 16'sh7FFF;
    lows[1]  = 16'sh7FFF; highs[1] = 16'sh8000;
    lows[2]  = '0;        highs[2] = '0;
    lows[3]  = 16'sh8000; highs[3] = 16'sh8000;
    lows[4]  = 16'sh7FFF; highs[4] = 16'sh7FFF;
    lows[5]  = -16'sd1000; highs[5] = 16'sd2500;
    lows[6]  = DataW'($urandom);  highs[6] = DataW'($urandom);
    lows[7]  = DataW'($urandom);  highs[7] = DataW'($urandom);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opener under the reset range (0 .. 32767)
    push_sample(16'sh8000, 1'b1);            // single sample: flat, most negative
    push_sample(16'sh7FFF, 1'b0);            // both extremes in one frame
    push_sample(16'sh8000, 1'b0);
    push_sample('0, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd12345, 1'b1);
    push_sample(16'sd7, 1'b0);               // flat frame of three
    push_sample(16'sd7, 1'b0);
    push_sample(16'sd7, 1'b1);
    push_sample(-16'sd5, 1'b0);              // two samples, small range
    push_sample(16'sd3, 1'b1);
    add_random_frames(14);

    for (int unsigned k = 0; k < NumRanges; k++) begin
      drain();
      write_reg(CfgOutLow, lows[k]);
      write_reg(CfgOutHigh, highs[k]);
      // exactly full store under the full range; overflow (frame_end itself
      // dropped) under the inverted range
      if (k == 0) add_frame(MaxSamples, FrmWide);
      if (k == 1) add_frame(MaxSamples + 3, FrmNarrow);
      add_random_frames(5);
    end
    drain();

    $display("Covered %0d frames (%0d flat, %0d over capacity), %0d result beats checked,",
             frames_closed, flat_frames, dropped_frames, results_checked);
    $display("across %0d output ranges incl. the reset range, extremes and inverted targets.",
             NumRanges + 1);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
